[rtl/glt_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph table lookup package
// Command codes, register indexes, field widths and the result record shared
// by the glyph table lookup modules.
// ----------------------------------------------------------------------------
package glt_pkg;

   localparam int CODE_W  = 21;
   localparam int ADV_W   = 5;
   localparam int COUNT_W = 9;
   localparam int DIM_W   = 5;
   localparam int CSR_W   = 9;
   localparam int OFF_W   = 7;

   localparam logic [1:0] CMD_LOAD_CODE = 2'd0;
   localparam logic [1:0] CMD_LOAD_BYTE = 2'd1;
   localparam logic [1:0] CMD_QUERY     = 2'd2;

   localparam logic [1:0] REG_GLYPH_COUNT  = 2'd0;
   localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd1;
   localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd2;

   typedef struct packed {
      logic              found;
      logic [7:0]        found_slot;
      logic [ADV_W-1:0]  glyph_advance;
      logic              pixel_on;
   } result_type;

   typedef struct packed {
      logic idle;
      logic done;
   } ctrl_status_type;

endpackage

[rtl/glyph_table_lookup.sv]
// A query runs a binary search of P probes, at most ceil(log2(n+1)) for n searched
// slots (9 at 256), then the advance and bitmap fetch. One query runs at a time on
// the shared code read port and compare; a load gives no result. A result held in
// the output register does not hold off input, but a later finished result does.
// Reset clears the sequencer, the result valid and the registers to count 0,
// width 8 and height 16; glyph memories are not cleared.
// ----------------------------------------------------------------------------
// Glyph table lookup
// Bitmap font glyph store with a binary-search codepoint lookup and a single
// pixel read from the found glyph's bitmap.
// ----------------------------------------------------------------------------
module glyph_table_lookup import glt_pkg::*; #(
   parameter int GLYPH_SLOTS      = 256,
   parameter int MAX_BITMAP_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_cmd,
   input  logic [7:0]        req_slot,
   input  logic [CODE_W-1:0] req_codepoint,
   input  logic [ADV_W-1:0]  req_advance,
   input  logic [4:0]        req_byte_offset,
   input  logic [7:0]        req_bitmap_byte,
   input  logic [3:0]        req_pixel_x,
   input  logic [3:0]        req_pixel_y,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_found,
   output logic [7:0]        rsp_found_slot,
   output logic [ADV_W-1:0]  rsp_glyph_advance,
   output logic              rsp_pixel_on,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int SLOT_W = $clog2(GLYPH_SLOTS);
   localparam int ADDR_W = $clog2(GLYPH_SLOTS * MAX_BITMAP_BYTES);

   logic [COUNT_W-1:0] count_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic               rsp_valid_ff;
   result_type         rsp_ff;

   logic               accept;
   logic               slot_ok;
   logic               wr_slot_en;
   logic               wr_byte_en;
   logic [SLOT_W-1:0]  wr_slot;
   logic [ADDR_W-1:0]  wr_byte_addr;
   logic               query_start;
   logic               take;
   logic [SLOT_W-1:0]  rd_slot;
   logic [ADDR_W-1:0]  rd_byte_addr;
   logic [CODE_W-1:0]  rd_code;
   logic [ADV_W-1:0]   rd_adv;
   logic [7:0]         rd_byte;
   ctrl_status_type    ctrl_status;
   result_type         ctrl_result;

   assign req_ready   = ctrl_status.idle;
   assign accept      = req_valid && req_ready;
   assign slot_ok     = 32'(req_slot) < GLYPH_SLOTS;
   assign wr_slot     = SLOT_W'(req_slot);
   assign wr_slot_en  = accept && (req_cmd == CMD_LOAD_CODE) && slot_ok;
   assign wr_byte_en  = accept && (req_cmd == CMD_LOAD_BYTE) && slot_ok &&
                        (32'(req_byte_offset) < MAX_BITMAP_BYTES);
   assign wr_byte_addr = ADDR_W'(wr_slot) * ADDR_W'(MAX_BITMAP_BYTES) +
                         ADDR_W'(req_byte_offset);
   assign query_start = accept && (req_cmd == CMD_QUERY);

   // A finished result moves to the output register once that register is free.
   assign take = ctrl_status.done && (!rsp_valid_ff || rsp_ready);

   glt_store #(
      .SLOTS (GLYPH_SLOTS),
      .BYTES (MAX_BITMAP_BYTES)
   ) u_store (
      .clock        (clock),
      .wr_slot_en   (wr_slot_en),
      .wr_slot      (wr_slot),
      .wr_code      (req_codepoint),
      .wr_adv       (req_advance),
      .wr_byte_en   (wr_byte_en),
      .wr_byte_addr (wr_byte_addr),
      .wr_byte      (req_bitmap_byte),
      .rd_slot      (rd_slot),
      .rd_byte_addr (rd_byte_addr),
      .rd_code      (rd_code),
      .rd_adv       (rd_adv),
      .rd_byte      (rd_byte)
   );

   glt_ctrl #(
      .SLOTS (GLYPH_SLOTS),
      .BYTES (MAX_BITMAP_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (query_start),
      .take         (take),
      .query_code   (req_codepoint),
      .query_x      (req_pixel_x),
      .query_y      (req_pixel_y),
      .cfg_count    (count_ff),
      .cfg_width    (width_ff),
      .cfg_height   (height_ff),
      .rd_code      (rd_code),
      .rd_adv       (rd_adv),
      .rd_byte      (rd_byte),
      .rd_slot      (rd_slot),
      .rd_byte_addr (rd_byte_addr),
      .status       (ctrl_status),
      .result       (ctrl_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= COUNT_W'(0);
         width_ff  <= DIM_W'(8);
         height_ff <= DIM_W'(16);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_GLYPH_COUNT:  count_ff  <= csr_wdata;
            REG_GLYPH_WIDTH:  width_ff  <= csr_wdata[DIM_W-1:0];
            REG_GLYPH_HEIGHT: height_ff <= csr_wdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= ctrl_result;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_ff.found;
   assign rsp_found_slot    = rsp_ff.found_slot;
   assign rsp_glyph_advance = rsp_ff.glyph_advance;
   assign rsp_pixel_on      = rsp_ff.pixel_on;

   // A miss carries no slot, advance or pixel.
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_found_slot == 8'd0 && rsp_glyph_advance == '0 && !rsp_pixel_on))
      else $error("miss result carries nonzero fields");

   // A query transfer holds off further input while the search runs.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_QUERY) |=> !req_ready)
      else $error("input ready right after a query transfer");

   // Load items never produce a result.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd != CMD_QUERY && !rsp_valid) |=> !rsp_valid)
      else $error("result appeared after a load transfer");

endmodule

[rtl/glt_store.sv]
// ----------------------------------------------------------------------------
// Glyph store
// Slot code and advance memory plus the bitmap byte memory, each with one
// write port and one registered read port.
// ----------------------------------------------------------------------------
module glt_store import glt_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int BYTES = 32,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int ADDR_W = $clog2(SLOTS * BYTES)
) (
   input  logic              clock,
   input  logic              wr_slot_en,
   input  logic [SLOT_W-1:0] wr_slot,
   input  logic [CODE_W-1:0] wr_code,
   input  logic [ADV_W-1:0]  wr_adv,
   input  logic              wr_byte_en,
   input  logic [ADDR_W-1:0] wr_byte_addr,
   input  logic [7:0]        wr_byte,
   input  logic [SLOT_W-1:0] rd_slot,
   input  logic [ADDR_W-1:0] rd_byte_addr,
   output logic [CODE_W-1:0] rd_code,
   output logic [ADV_W-1:0]  rd_adv,
   output logic [7:0]        rd_byte
);

   logic [CODE_W-1:0] code_mem [SLOTS];
   logic [ADV_W-1:0]  adv_mem  [SLOTS];
   logic [7:0]        byte_mem [SLOTS * BYTES];

   always_ff @(posedge clock) begin
      if (wr_slot_en) begin
         code_mem[wr_slot] <= wr_code;
         adv_mem[wr_slot]  <= wr_adv;
      end
      rd_code <= code_mem[rd_slot];
      rd_adv  <= adv_mem[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (wr_byte_en) begin
         byte_mem[wr_byte_addr] <= wr_byte;
      end
      rd_byte <= byte_mem[rd_byte_addr];
   end

endmodule

[rtl/glt_ctrl.sv]
// ----------------------------------------------------------------------------
// Glyph search sequencer
// Binary search over the slot codes with one shared compare, each probe passing
// through S_PROBE and S_COMPARE, followed by the advance and bitmap fetch for the final slot.
// ----------------------------------------------------------------------------
module glt_ctrl import glt_pkg::*; #(
   parameter int SLOTS = 256,
   parameter int BYTES = 32,
   localparam int SLOT_W = $clog2(SLOTS),
   localparam int ADDR_W = $clog2(SLOTS * BYTES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               take,
   input  logic [CODE_W-1:0]  query_code,
   input  logic [3:0]         query_x,
   input  logic [3:0]         query_y,
   input  logic [COUNT_W-1:0] cfg_count,
   input  logic [DIM_W-1:0]   cfg_width,
   input  logic [DIM_W-1:0]   cfg_height,
   input  logic [CODE_W-1:0]  rd_code,
   input  logic [ADV_W-1:0]   rd_adv,
   input  logic [7:0]         rd_byte,
   output logic [SLOT_W-1:0]  rd_slot,
   output logic [ADDR_W-1:0]  rd_byte_addr,
   output ctrl_status_type    status,
   output result_type         result
);

   localparam int IDX_W = $clog2(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PROBE, S_COMPARE, S_FETCH, S_CHECK, S_FINISH
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  lo_ff;
   logic [IDX_W-1:0]  hi_ff;
   logic [IDX_W-1:0]  n_ff;
   logic [IDX_W-1:0]  mid_ff;
   logic [CODE_W-1:0] code_ff;
   logic [OFF_W-1:0]  off_ff;
   logic              inside_ff;
   logic [2:0]        bit_ff;
   result_type        result_ff;

   logic [IDX_W-1:0]  mid_in;
   logic [IDX_W-1:0]  n_in;
   logic [2:0]        row_len;
   logic [OFF_W-1:0]  off_in;
   logic              inside_in;
   logic              found_in;
   logic [ADDR_W-1:0] base_addr;

   assign mid_in = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign n_in   = (32'(cfg_count) > SLOTS) ? IDX_W'(SLOTS) : IDX_W'(cfg_count);

   // Rows are ceil(width/8) bytes long, pixels MSB first.
   assign row_len   = 3'((6'(cfg_width) + 6'd7) >> 3);
   assign off_in    = OFF_W'(query_y) * OFF_W'(row_len) + OFF_W'(query_x[3]);
   assign inside_in = (DIM_W'(query_x) < cfg_width) && (DIM_W'(query_y) < cfg_height) &&
                      (32'(off_in) < BYTES);

   assign base_addr    = ADDR_W'(SLOT_W'(lo_ff)) * ADDR_W'(BYTES);
   assign rd_byte_addr = base_addr + ADDR_W'(off_ff);
   assign rd_slot      = (state_ff == S_FETCH) ? SLOT_W'(lo_ff) : SLOT_W'(mid_in);

   assign found_in = (lo_ff < n_ff) && (rd_code == code_ff);

   assign status.idle = (state_ff == S_IDLE);
   assign status.done = (state_ff == S_FINISH);
   assign result      = result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  code_ff   <= query_code;
                  off_ff    <= off_in;
                  inside_ff <= inside_in;
                  bit_ff    <= query_x[2:0];
                  lo_ff     <= '0;
                  hi_ff     <= n_in;
                  n_ff      <= n_in;
                  state_ff  <= S_PROBE;
               end
            end
            S_PROBE: begin
               if (lo_ff < hi_ff) begin
                  mid_ff   <= mid_in;
                  state_ff <= S_COMPARE;
               end else begin
                  state_ff <= S_FETCH;
               end
            end
            S_COMPARE: begin
               // The code read at the midpoint arrives in the cycle after the probe.
               if (rd_code < code_ff) begin
                  lo_ff <= mid_ff + IDX_W'(1);
               end else begin
                  hi_ff <= mid_ff;
               end
               state_ff <= S_PROBE;
            end
            S_FETCH: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               result_ff.found         <= found_in;
               result_ff.found_slot    <= found_in ? 8'(lo_ff) : 8'd0;
               result_ff.glyph_advance <= found_in ? rd_adv : '0;
               result_ff.pixel_on      <= found_in && inside_ff && rd_byte[3'd7 - bit_ff];
               state_ff                <= S_FINISH;
            end
            S_FINISH: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[tb/glyph_table_lookup_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph table lookup testbench
// Loads glyph fonts of several sizes and orderings, runs codepoint and pixel
// queries under random flow control and compares every response with a
// binary-search predictor that keeps its own copy of the glyph tables.
// ----------------------------------------------------------------------------
module glyph_table_lookup_tb;
   import glt_pkg::*;

   localparam int GLYPH_SLOTS  = 256;
   localparam int GLYPH_BYTES  = 32;
   localparam int CODE_MAX     = (1 << CODE_W) - 1;
   localparam int SETTLE_CYCLES = 24;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef enum int {FONT_ASCENDING, FONT_DUPLICATES, FONT_SHUFFLED} font_style_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [7:0]        slot;
      logic [CODE_W-1:0] codepoint;
      logic [ADV_W-1:0]  advance;
      logic [4:0]        byte_offset;
      logic [7:0]        bitmap_byte;
      logic [3:0]        pixel_x;
      logic [3:0]        pixel_y;
   } glyph_req_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_cmd = CMD_LOAD_CODE;
   logic [7:0]        req_slot = '0;
   logic [CODE_W-1:0] req_codepoint = '0;
   logic [ADV_W-1:0]  req_advance = '0;
   logic [4:0]        req_byte_offset = '0;
   logic [7:0]        req_bitmap_byte = '0;
   logic [3:0]        req_pixel_x = '0;
   logic [3:0]        req_pixel_y = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_found;
   logic [7:0]        rsp_found_slot;
   logic [ADV_W-1:0]  rsp_glyph_advance;
   logic              rsp_pixel_on;
   logic              csr_wr_en = 1'b0;
   logic [1:0]        csr_index = REG_GLYPH_COUNT;
   logic [CSR_W-1:0]  csr_wdata = '0;

   // Mirror of the glyph tables and registers as the block should hold them.
   logic [CODE_W-1:0] font_codes    [GLYPH_SLOTS];
   logic [ADV_W-1:0]  font_advances [GLYPH_SLOTS];
   logic [7:0]        font_bitmap   [GLYPH_SLOTS*GLYPH_BYTES];
   bit                byte_loaded   [GLYPH_SLOTS*GLYPH_BYTES];
   int                cur_count  = 0;
   int                cur_width  = 8;
   int                cur_height = 16;

   result_type        pending_lookups [$];
   int                mismatch_count = 0;
   int                feed_gap_max   = 14;
   int                sink_stall_max = 14;

   glyph_table_lookup #(
      .GLYPH_SLOTS      (GLYPH_SLOTS),
      .MAX_BITMAP_BYTES (GLYPH_BYTES)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_slot          (req_slot),
      .req_codepoint     (req_codepoint),
      .req_advance       (req_advance),
      .req_byte_offset   (req_byte_offset),
      .req_bitmap_byte   (req_bitmap_byte),
      .req_pixel_x       (req_pixel_x),
      .req_pixel_y       (req_pixel_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_found_slot    (rsp_found_slot),
      .rsp_glyph_advance (rsp_glyph_advance),
      .rsp_pixel_on      (rsp_pixel_on),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #12_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 100)
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic int searched_slots();
      return (cur_count > GLYPH_SLOTS) ? GLYPH_SLOTS : cur_count;
   endfunction

   // Byte offset of a pixel within a glyph bitmap, or -1 when the pixel lies
   // outside the glyph or past the end of the bitmap storage.
   function automatic int pixel_byte(input logic [3:0] px, input logic [3:0] py);
      int row_len, off;
      if (px >= cur_width || py >= cur_height) return -1;
      row_len = (cur_width + 7) / 8;
      off = py * row_len + px / 8;
      return (off < GLYPH_BYTES) ? off : -1;
   endfunction

   function automatic result_type lookup_glyph(input logic [CODE_W-1:0] code,
                                               input logic [3:0] px,
                                               input logic [3:0] py);
      result_type r;
      int n, lo, hi, mid, off, bit_pos;
      r = '0;
      n = searched_slots();
      lo = 0;
      hi = n;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (font_codes[mid] < code) lo = mid + 1;
         else hi = mid;
      end
      if (lo < n && font_codes[lo] == code) begin
         r.found = 1'b1;
         r.found_slot = 8'(lo);
         r.glyph_advance = font_advances[lo];
         off = pixel_byte(px, py);
         bit_pos = 7 - px % 8;
         if (off >= 0) r.pixel_on = font_bitmap[lo * GLYPH_BYTES + off][bit_pos];
      end
      return r;
   endfunction

   function automatic glyph_req_type noise_req();
      glyph_req_type r;
      r.cmd         = 2'($urandom_range(0, 3));
      r.slot        = 8'($urandom_range(0, 255));
      r.codepoint   = CODE_W'($urandom_range(0, CODE_MAX));
      r.advance     = ADV_W'($urandom_range(0, 31));
      r.byte_offset = 5'($urandom_range(0, 31));
      r.bitmap_byte = 8'($urandom_range(0, 255));
      r.pixel_x     = 4'($urandom_range(0, 15));
      r.pixel_y     = 4'($urandom_range(0, 15));
      return r;
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      int n, roll;
      logic [CODE_W-1:0] known;
      n = searched_slots();
      roll = $urandom_range(0, 9);
      if (n == 0 || roll >= 8) return CODE_W'($urandom_range(0, CODE_MAX));
      known = font_codes[$urandom_range(0, n - 1)];
      if (roll < 6) return known;
      return (roll == 6) ? known + 1'b1 : known - 1'b1;
   endfunction

   function automatic int pick_dim();
      int dim_corners [9] = '{0, 1, 7, 8, 9, 15, 16, 17, 31};
      return ($urandom_range(0, 2) == 0) ? dim_corners[$urandom_range(0, 8)]
                                         : $urandom_range(1, 16);
   endfunction

   function automatic int pick_pace();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         default: return 14;
      endcase
   endfunction

   // Offers one item and waits for its transfer, then applies it to the mirror.
   // Valid is left high afterwards, so anything that lets time pass without
   // offering a new item must lower it first.
   task automatic send_item(input glyph_req_type r);
      int gap;
      gap = $urandom_range(0, feed_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= r.cmd;
      req_slot        <= r.slot;
      req_codepoint   <= r.codepoint;
      req_advance     <= r.advance;
      req_byte_offset <= r.byte_offset;
      req_bitmap_byte <= r.bitmap_byte;
      req_pixel_x     <= r.pixel_x;
      req_pixel_y     <= r.pixel_y;
      do @(posedge clock); while (!req_ready);
      case (r.cmd)
         CMD_LOAD_CODE: begin
            font_codes[r.slot]    = r.codepoint;
            font_advances[r.slot] = r.advance;
         end
         CMD_LOAD_BYTE: begin
            font_bitmap[r.slot * GLYPH_BYTES + r.byte_offset] = r.bitmap_byte;
            byte_loaded[r.slot * GLYPH_BYTES + r.byte_offset] = 1'b1;
         end
         CMD_QUERY: pending_lookups.push_back(lookup_glyph(r.codepoint, r.pixel_x,
                                                           r.pixel_y));
         default: ;
      endcase
   endtask

   task automatic load_code(input logic [7:0] slot, input logic [CODE_W-1:0] code,
                            input logic [ADV_W-1:0] adv);
      glyph_req_type r;
      r = noise_req();
      r.cmd = CMD_LOAD_CODE;
      r.slot = slot;
      r.codepoint = code;
      r.advance = adv;
      send_item(r);
   endtask

   task automatic load_byte(input logic [7:0] slot, input logic [4:0] off,
                            input logic [7:0] value);
      glyph_req_type r;
      r = noise_req();
      r.cmd = CMD_LOAD_BYTE;
      r.slot = slot;
      r.byte_offset = off;
      r.bitmap_byte = value;
      send_item(r);
   endtask

   // A query must never read a bitmap byte that was never loaded, so the byte
   // it will touch gets a random value first when it is still blank.
   task automatic query(input logic [CODE_W-1:0] code, input logic [3:0] px,
                        input logic [3:0] py);
      glyph_req_type r;
      result_type hit;
      int off, s;
      hit = lookup_glyph(code, px, py);
      off = pixel_byte(px, py);
      s = int'(hit.found_slot);
      if (hit.found && off >= 0 && !byte_loaded[s * GLYPH_BYTES + off])
         load_byte(hit.found_slot, 5'(off), 8'($urandom_range(0, 255)));
      r = noise_req();
      r.cmd = CMD_QUERY;
      r.codepoint = code;
      r.pixel_x = px;
      r.pixel_y = py;
      send_item(r);
   endtask

   task automatic send_unused();
      glyph_req_type r;
      r = noise_req();
      r.cmd = CMD_UNUSED;
      send_item(r);
   endtask

   task automatic release_feed();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic hold_for_results();
      release_feed();
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_W'(value);
      @(posedge clock);
   endtask

   // Loads that give no response may still be in flight after the last
   // response, hence the extra settle time before the registers change.
   task automatic program_font(input int count, input int width, input int height);
      hold_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(REG_GLYPH_COUNT, count);
      write_reg(REG_GLYPH_WIDTH, width);
      write_reg(REG_GLYPH_HEIGHT, height);
      csr_wr_en <= 1'b0;
      cur_count  = count & 9'h1FF;
      cur_width  = width & 5'h1F;
      cur_height = height & 5'h1F;
   endtask

   task automatic build_font(input int n, input font_style_type style);
      int span;
      logic [CODE_W-1:0] code, prev;
      span = (n > 0) ? (CODE_MAX + 1) / n : 1;
      prev = '0;
      for (int i = 0; i < n && i < GLYPH_SLOTS; i++) begin
         case (style)
            FONT_SHUFFLED: code = CODE_W'($urandom_range(0, CODE_MAX));
            FONT_DUPLICATES: code = (i > 0 && $urandom_range(0, 2) == 0) ? prev :
                                    CODE_W'(i * span + $urandom_range(0, span - 1));
            default: code = CODE_W'(i * span + $urandom_range(0, span - 1));
         endcase
         load_code(8'(i), code, ADV_W'($urandom_range(0, 31)));
         prev = code;
      end
   endtask

   task automatic mixed_traffic(input int steps);
      int roll;
      for (int i = 0; i < steps; i++) begin
         if (i % 25 == 0) begin
            feed_gap_max   = pick_pace();
            sink_stall_max = pick_pace();
         end
         roll = $urandom_range(0, 99);
         if (roll < 72)
            query(pick_code(), 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         else if (roll < 87)
            load_byte(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
                      8'($urandom_range(0, 255)));
         else if (roll < 92)
            load_code(8'($urandom_range(0, 255)), CODE_W'($urandom_range(0, CODE_MAX)),
                      ADV_W'($urandom_range(0, 31)));
         else if (roll < 97)
            send_unused();
         else
            hold_for_results();
      end
   endtask

   task automatic test_after_reset();
      // No slots are searched yet, so every query misses.
      query('0, 0, 0);
      query(CODE_W'(CODE_MAX), 15, 15);
      send_unused();
      query(21'h000041, 3, 9);
   endtask

   task automatic test_directed_font();
      load_code(0, '0, 0);
      load_code(1, 21'h000041, 16);
      load_code(2, CODE_W'(CODE_MAX), 31);
      load_byte(0, 0, 8'h7F);
      load_byte(1, 31, 8'h01);
      load_byte(2, 16, 8'h80);
      program_font(3, 16, 16);
      query('0, 0, 0);
      query(21'h000041, 15, 15);
      query(CODE_W'(CODE_MAX), 0, 8);
      query(21'h000040, 3, 3);
      query(21'h000042, 3, 3);
      query(CODE_W'(CODE_MAX - 1), 0, 0);
      // A zero width or height puts every pixel outside the glyph.
      program_font(3, 0, 16);
      query(21'h000041, 0, 0);
      program_font(3, 16, 0);
      query('0, 0, 0);
      // Wide rows push the lower pixels past the end of the bitmap storage.
      program_font(3, 31, 31);
      query(21'h000041, 15, 15);
      query(21'h000041, 0, 7);
      program_font(1, 1, 1);
      query(21'h000041, 0, 0);
      query('0, 0, 0);
      query('0, 1, 0);
   endtask

   task automatic test_full_table();
      int count;
      build_font(GLYPH_SLOTS, FONT_ASCENDING);
      // Counts above the table size still search only the stored slots.
      for (int k = 0; k < 3; k++) begin
         count = (k == 0) ? GLYPH_SLOTS :
                 (k == 1) ? $urandom_range(GLYPH_SLOTS + 1, 510) : 511;
         program_font(count, pick_dim(), pick_dim());
         mixed_traffic(70);
      end
   endtask

   task automatic test_random_fonts();
      int count;
      font_style_type style;
      for (int p = 0; p < 10; p++) begin
         count = (p == 0) ? 1 : (p == 1) ? 2 : (p == 2) ? 0 : $urandom_range(3, 48);
         style = (p % 5 == 4) ? FONT_SHUFFLED :
                 (p % 5 == 3) ? FONT_DUPLICATES : FONT_ASCENDING;
         build_font(count, style);
         program_font(count, pick_dim(), pick_dim());
         mixed_traffic(115);
      end
   endtask

   initial begin : result_checker
      result_type want;
      int stall;
      wait (reset == 1'b0);
      @(posedge clock);
      rsp_ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
         if (pending_lookups.size() == 0) begin
            report_mismatch("response with no query pending", 32'(rsp_found_slot), 0);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found)
               report_mismatch("found", 32'(rsp_found), 32'(want.found));
            if (rsp_found_slot !== want.found_slot)
               report_mismatch("found_slot", 32'(rsp_found_slot), 32'(want.found_slot));
            if (rsp_glyph_advance !== want.glyph_advance)
               report_mismatch("glyph_advance", 32'(rsp_glyph_advance),
                               32'(want.glyph_advance));
            if (rsp_pixel_on !== want.pixel_on)
               report_mismatch("pixel_on", 32'(rsp_pixel_on), 32'(want.pixel_on));
         end
         stall = $urandom_range(0, sink_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_directed_font();
      test_full_table();
      test_random_fonts();
      release_feed();
      for (int i = 0; i < 5000 && pending_lookups.size() != 0; i++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_lookups.size() != 0)
         report_mismatch("queries never answered", 32'(pending_lookups.size()), 0);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
